@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros used by floyd_warshall_all_pairs
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on clk, off while rst_n is low
`define FW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define FW_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ src/fw_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// fw_pkg
// types and constants of the all-pairs shortest path block
// ============================================================================
package fw_pkg;

    localparam int DIST_W = 24;

    typedef logic signed [DIST_W-1:0] dist_t;
    typedef logic signed [DIST_W:0]   dist_sum_t;

    localparam dist_t DIST_INF     = 24'sh7FFFFF;
    localparam dist_t DIST_FIN_MAX = 24'sh7FFFFE;
    localparam dist_t DIST_MIN     = 24'sh800000;

    localparam dist_sum_t SUM_FIN_MAX = 25'sh07FFFFE;
    localparam dist_sum_t SUM_MIN     = 25'sh1800000;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_EDGE  = 2'd1,
        REQ_RUN   = 2'd2,
        REQ_READ  = 2'd3
    } req_t;

    typedef struct packed {
        logic  upd;
        dist_t value;
    } fw_relax_t;

endpackage

@@ src/fw_alu.sv @@
`timescale 1ns / 1ps
// ============================================================================
// fw_alu
// relaxation unit: saturating add of two path legs and compare to the entry
// ============================================================================
module fw_alu
(
    input  fw_pkg::dist_t     ik,
    input  fw_pkg::dist_t     kj,
    input  fw_pkg::dist_t     ij,
    output fw_pkg::fw_relax_t res
);
    import fw_pkg::*;

    dist_sum_t sum;
    dist_t     sat;
    logic      any_inf;

    assign any_inf = (ik == DIST_INF) || (kj == DIST_INF);
    assign sum     = dist_sum_t'(ik) + dist_sum_t'(kj);

    // finite sums never reach the infinity code
    always_comb
    begin
        priority if (sum > SUM_FIN_MAX)
        begin
            sat = DIST_FIN_MAX;
        end
        else if (sum < SUM_MIN)
        begin
            sat = DIST_MIN;
        end
        else
        begin
            sat = sum[DIST_W-1:0];
        end
    end

    assign res.upd   = !any_inf && (ij > sat);
    assign res.value = sat;

endmodule

@@ src/fw_mem.sv @@
`timescale 1ns / 1ps
// ============================================================================
// fw_mem
// distance matrix store, one write port and two registered read ports
// ============================================================================
module fw_mem
#(
    parameter int AW = 8
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  fw_pkg::dist_t wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output fw_pkg::dist_t rdata_a,
    output fw_pkg::dist_t rdata_b
);
    import fw_pkg::*;

    localparam int DEPTH = 2 ** AW;

    dist_t mem [DEPTH];
    dist_t rdata_a_reg;
    dist_t rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

@@ src/floyd_warshall_all_pairs.sv @@
`timescale 1ns / 1ps
// ============================================================================
// floyd_warshall_all_pairs
// all-pairs shortest path over a square distance matrix, one relaxation
// unit stepped through k, i and j by a small sequencer
// ============================================================================
//
//  channel   ports                                      handshake
//  --------  -----------------------------------------  ---------------------
//  request   req_type vertex_a vertex_b weight          start high, busy low
//  result    distance unreachable bad_vertex            done, one cycle
//  config    cfg_wdata (num_vertices)                   cfg_we
//
//  run: paced by the single relaxation unit and the memory write port, one entry
//  a cycle within a row, with a read of the ik entry ahead of each row
//  clear fills every entry; add edge writes both directions; read one entry
//  after reset a clearing pass over all 4**VW entries (256 at 16 vertices) runs
//  with busy high and gives no result
//  done is never held off: the result stands for its one cycle only
//
module floyd_warshall_all_pairs
#(
    parameter int MAX_VERTICES = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  fw_pkg::req_t                       req_type,
    input  logic [$clog2(MAX_VERTICES)-1:0]    vertex_a,
    input  logic [$clog2(MAX_VERTICES)-1:0]    vertex_b,
    input  fw_pkg::dist_t                      weight,
    output logic                               done,
    output fw_pkg::dist_t                      distance,
    output logic                               unreachable,
    output logic                               bad_vertex,
    input  logic                               cfg_we,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]  cfg_wdata
);
    import fw_pkg::*;

`include "assert_macros.svh"

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int NVW = $clog2(MAX_VERTICES + 1);
    localparam int AW  = 2 * VW;
    localparam logic [NVW-1:0] N_MAX = NVW'(MAX_VERTICES);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CLEAR = 10'b0000000010,
        S_DIAG  = 10'b0000000100,
        S_ROWRD = 10'b0000001000,
        S_COL   = 10'b0000010000,
        S_TAIL  = 10'b0000100000,
        S_EDGE1 = 10'b0001000000,
        S_EDGE2 = 10'b0010000000,
        S_READ  = 10'b0100000000,
        S_RDOUT = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [NVW-1:0] n_reg, n_next;
    logic [VW-1:0]  k_reg, k_next;
    logic [VW-1:0]  i_reg, i_next;
    logic [VW-1:0]  j_reg, j_next;
    logic [VW-1:0]  pi_reg, pi_next;
    logic [VW-1:0]  pj_reg, pj_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic           init_reg, init_next;
    logic           ik_load_reg, ik_load_next;
    logic           p_valid_reg, p_valid_next;
    logic           done_reg, done_next;
    dist_t          ik_reg, ik_next;

    logic [VW-1:0]  op_a_reg, op_a_next;
    logic [VW-1:0]  op_b_reg, op_b_next;
    dist_t          op_w_reg, op_w_next;
    dist_t          res_dist_reg, res_dist_next;
    logic           res_unreach_reg, res_unreach_next;
    logic           res_bad_reg, res_bad_next;

    logic [NVW-1:0] n_use;
    logic           last_i;
    logic           last_j;
    logic           last_k;
    logic           bad_in;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    dist_t          mem_wdata;
    logic [AW-1:0]  mem_raddr_a;
    logic [AW-1:0]  mem_raddr_b;
    dist_t          qa;
    dist_t          qb;
    fw_relax_t      relax;

    assign n_use  = (n_reg > N_MAX) ? N_MAX : n_reg;
    assign last_i = (NVW'(i_reg) + NVW'(1)) == n_use;
    assign last_j = (NVW'(j_reg) + NVW'(1)) == n_use;
    assign last_k = (NVW'(k_reg) + NVW'(1)) == n_use;
    assign bad_in = (NVW'(vertex_a) >= n_use) || (NVW'(vertex_b) >= n_use);
    assign n_next = cfg_we ? cfg_wdata : n_reg;

    fw_mem #(
        .AW (AW)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (qa),
        .rdata_b (qb)
    );

    // ik from the held register, kj and ij straight from the read ports
    fw_alu u_alu (
        .ik  (ik_reg),
        .kj  (qa),
        .ij  (qb),
        .res (relax)
    );

    always_comb
    begin
        state_next       = state_reg;
        k_next           = k_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        pi_next          = pi_reg;
        pj_next          = pj_reg;
        clr_next         = clr_reg;
        init_next        = init_reg;
        ik_load_next     = 1'b0;
        p_valid_next     = 1'b0;
        done_next        = 1'b0;
        op_a_next        = op_a_reg;
        op_b_next        = op_b_reg;
        op_w_next        = op_w_reg;
        res_dist_next    = '0;
        res_unreach_next = 1'b0;
        res_bad_next     = 1'b0;

        mem_we      = 1'b0;
        mem_waddr   = {pi_reg, pj_reg};
        mem_wdata   = relax.value;
        mem_raddr_a = {k_reg, j_reg};
        mem_raddr_b = {i_reg, j_reg};

        // write-back of the element read in the previous cycle
        if (p_valid_reg && relax.upd)
        begin
            mem_we = 1'b1;
        end

        // ik follows its own entry when j passes k
        if (ik_load_reg)
        begin
            ik_next = qa;
        end
        else if (p_valid_reg && relax.upd && (pj_reg == k_reg))
        begin
            ik_next = relax.value;
        end
        else
        begin
            ik_next = ik_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_a_next = vertex_a;
                    op_b_next = vertex_b;
                    op_w_next = weight;
                    unique case (req_type)
                        REQ_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        REQ_RUN:
                        begin
                            if (n_use == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                i_next     = '0;
                                state_next = S_DIAG;
                            end
                        end
                        REQ_EDGE:
                        begin
                            if (bad_in)
                            begin
                                done_next    = 1'b1;
                                res_bad_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_EDGE1;
                            end
                        end
                        REQ_READ:
                        begin
                            if (bad_in)
                            begin
                                done_next    = 1'b1;
                                res_bad_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = DIST_INF;
                clr_next  = clr_reg + AW'(1);
                if (&clr_reg)
                begin
                    // the pass after reset gives no result
                    done_next  = !init_reg;
                    init_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_DIAG:
            begin
                mem_we    = 1'b1;
                mem_waddr = {i_reg, i_reg};
                mem_wdata = '0;
                if (last_i)
                begin
                    i_next     = '0;
                    k_next     = '0;
                    state_next = S_ROWRD;
                end
                else
                begin
                    i_next = i_reg + VW'(1);
                end
            end
            S_ROWRD:
            begin
                mem_raddr_a  = {i_reg, k_reg};
                ik_load_next = 1'b1;
                j_next       = '0;
                state_next   = S_COL;
            end
            S_COL:
            begin
                p_valid_next = 1'b1;
                pi_next      = i_reg;
                pj_next      = j_reg;
                if (last_j)
                begin
                    j_next = '0;
                    if (last_i)
                    begin
                        i_next = '0;
                        if (last_k)
                        begin
                            state_next = S_TAIL;
                        end
                        else
                        begin
                            k_next     = k_reg + VW'(1);
                            state_next = S_ROWRD;
                        end
                    end
                    else
                    begin
                        i_next     = i_reg + VW'(1);
                        state_next = S_ROWRD;
                    end
                end
                else
                begin
                    j_next = j_reg + VW'(1);
                end
            end
            S_TAIL:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_EDGE1:
            begin
                mem_we     = 1'b1;
                mem_waddr  = {op_a_reg, op_b_reg};
                mem_wdata  = op_w_reg;
                state_next = S_EDGE2;
            end
            S_EDGE2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = {op_b_reg, op_a_reg};
                mem_wdata  = op_w_reg;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_READ:
            begin
                mem_raddr_b = {op_a_reg, op_b_reg};
                state_next  = S_RDOUT;
            end
            S_RDOUT:
            begin
                done_next        = 1'b1;
                res_dist_next    = qb;
                res_unreach_next = (qb == DIST_INF);
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            n_reg       <= N_MAX;
            k_reg       <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            clr_reg     <= '0;
            init_reg    <= 1'b1;
            ik_load_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            k_reg       <= k_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            clr_reg     <= clr_next;
            init_reg    <= init_next;
            ik_load_reg <= ik_load_next;
            p_valid_reg <= p_valid_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pi_reg          <= pi_next;
        pj_reg          <= pj_next;
        ik_reg          <= ik_next;
        op_a_reg        <= op_a_next;
        op_b_reg        <= op_b_next;
        op_w_reg        <= op_w_next;
        res_dist_reg    <= res_dist_next;
        res_unreach_reg <= res_unreach_next;
        res_bad_reg     <= res_bad_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign distance    = res_dist_reg;
    assign unreachable = res_unreach_reg;
    assign bad_vertex  = res_bad_reg;

    `FW_ASSERT_IMPL(a_unreach_is_inf, done && unreachable, distance == DIST_INF,
        "unreachable result without the infinity code")
    `FW_ASSERT_IMPL(a_bad_is_quiet, done && bad_vertex, (distance == '0) && !unreachable,
        "bad vertex result carries a distance")
    `FW_ASSERT_IMPL(a_write_when_busy, mem_we, busy, "matrix written while idle")
    `FW_ASSERT_IMPL(a_pipe_in_run, p_valid_reg,
        (state_reg == S_COL) || (state_reg == S_ROWRD) || (state_reg == S_TAIL),
        "relaxation write-back outside a run")

endmodule

@@ test/floyd_warshall_all_pairs_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// floyd_warshall_all_pairs_tb
// drives clear, add-edge, run and read requests into the shortest path block
// under several vertex counts, keeps its own copy of the distance matrix and
// checks every answer field by field against it, in order
// ============================================================================

localparam int NV_MAX        = 16;
localparam int INF_CODE      = fw_pkg::DIST_INF;
localparam int FIN_MAX_CODE  = fw_pkg::DIST_FIN_MAX;
localparam int MIN_CODE      = fw_pkg::DIST_MIN;
localparam int CYCLE_LIMIT   = 2000000;

typedef struct packed {
    fw_pkg::req_t  req;
    logic [3:0]    va;
    logic [3:0]    vb;
    fw_pkg::dist_t dist_val;
    logic          unreach;
    logic          bad;
} fw_answer_t;

class dist_scoreboard;
    fw_pkg::dist_t dist_copy [0:NV_MAX*NV_MAX-1];
    int            nverts;
    fw_answer_t    pending_answers [$];
    int            errors;
    int            n_runs, n_edges, n_reads, n_clears, n_bad, n_useful, n_checked;

    function new();
        nverts = NV_MAX;
        foreach (dist_copy[i])
            dist_copy[i] = fw_pkg::DIST_INF;
    endfunction

    // full relaxation over the vertices in use, saturating finite sums
    function void relax_copy(int n);
        int ik, kj, sum;
        for (int i = 0; i < n; i++)
            dist_copy[i*NV_MAX + i] = '0;
        for (int k = 0; k < n; k++)
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++)
                begin
                    ik = dist_copy[i*NV_MAX + k];
                    kj = dist_copy[k*NV_MAX + j];
                    if (ik == INF_CODE || kj == INF_CODE)
                        continue;
                    sum = ik + kj;
                    if (sum > FIN_MAX_CODE)
                        sum = FIN_MAX_CODE;
                    if (sum < MIN_CODE)
                        sum = MIN_CODE;
                    if (int'(dist_copy[i*NV_MAX + j]) > sum)
                        dist_copy[i*NV_MAX + j] = fw_pkg::dist_t'(sum);
                end
    endfunction

    function void note_request(fw_pkg::req_t r, logic [3:0] a, logic [3:0] b,
                               fw_pkg::dist_t w);
        fw_answer_t ans;
        int         n;
        n = (nverts > NV_MAX) ? NV_MAX : nverts;
        ans = '{req: r, va: a, vb: b, dist_val: '0, unreach: 1'b0, bad: 1'b0};
        if (r == fw_pkg::REQ_CLEAR)
        begin
            foreach (dist_copy[i])
                dist_copy[i] = fw_pkg::DIST_INF;
            n_clears++;
        end
        else if (r == fw_pkg::REQ_RUN)
        begin
            relax_copy(n);
            n_runs++;
        end
        else if (int'(a) >= n || int'(b) >= n)
        begin
            ans.bad = 1'b1;
            n_bad++;
        end
        else if (r == fw_pkg::REQ_EDGE)
        begin
            dist_copy[a*NV_MAX + b] = w;
            dist_copy[b*NV_MAX + a] = w;
            n_edges++;
        end
        else
        begin
            ans.dist_val = dist_copy[a*NV_MAX + b];
            ans.unreach  = (ans.dist_val == fw_pkg::DIST_INF);
            n_reads++;
        end
        if (!ans.bad)
            n_useful++;
        pending_answers.push_back(ans);
    endfunction

    task report(string msg);
        errors++;
        $display("mismatch %0d at %0t: %s", errors, $realtime, msg);
    endtask

    task check_answer(fw_pkg::dist_t d, logic u, logic bv);
        fw_answer_t want;
        if (pending_answers.size() == 0)
        begin
            report($sformatf("answer with nothing pending (distance %0d)", d));
            return;
        end
        want = pending_answers.pop_front();
        n_checked++;
        if (d !== want.dist_val)
            report($sformatf("%s %0d,%0d distance %0d, wanted %0d",
                             want.req.name(), want.va, want.vb, d, want.dist_val));
        if (u !== want.unreach)
            report($sformatf("%s %0d,%0d unreachable %b, wanted %b",
                             want.req.name(), want.va, want.vb, u, want.unreach));
        if (bv !== want.bad)
            report($sformatf("%s %0d,%0d bad_vertex %b, wanted %b",
                             want.req.name(), want.va, want.vb, bv, want.bad));
    endtask

    task check_leftovers();
        fw_answer_t left;
        while (pending_answers.size() != 0)
        begin
            left = pending_answers.pop_front();
            report($sformatf("no answer came for %s", left.req.name()));
        end
    endtask
endclass

module floyd_warshall_all_pairs_tb;
    import fw_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    req_t       req_type;
    logic [3:0] vertex_a;
    logic [3:0] vertex_b;
    dist_t      weight;
    logic       done;
    dist_t      distance;
    logic       unreachable;
    logic       bad_vertex;
    logic       cfg_we;
    logic [4:0] cfg_wdata;

    dist_scoreboard sb;
    bit             sender_idles;
    int             cycles;

    floyd_warshall_all_pairs #(.MAX_VERTICES(NV_MAX)) dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .vertex_a    (vertex_a),
        .vertex_b    (vertex_b),
        .weight      (weight),
        .done        (done),
        .distance    (distance),
        .unreachable (unreachable),
        .bad_vertex  (bad_vertex),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_answer(distance, unreachable, bad_vertex);
    end

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d answers outstanding",
                 cycles, sb.pending_answers.size());
        $display("FAIL");
        $finish;
    end

    // mostly small Q20.4 weights so paths matter, plus the extremes and infinity
    function automatic dist_t pick_weight();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return dist_t'(int'($urandom_range(320)) - 64);
        else if (sel < 55)
            return dist_t'($urandom());
        else if (sel < 65)
            return DIST_INF;
        else if (sel < 75)
            return dist_t'(FIN_MAX_CODE - int'($urandom_range(1000)));
        else if (sel < 85)
            return dist_t'(MIN_CODE + int'($urandom_range(1000)));
        return dist_t'(int'($urandom_range(1, 64)));
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(req_t r, logic [3:0] a, logic [3:0] b, dist_t w);
        int gap;
        if (sender_idles && $urandom_range(99) < 7)
        begin
            start <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge clk);
        end
        start    <= 1'b1;
        req_type <= r;
        vertex_a <= a;
        vertex_b <= b;
        weight   <= w;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(r, a, b, w);
        @(negedge clk);
    endtask

    // only while idle: every answer in and busy low
    task automatic write_vertex_count(int v);
        start <= 1'b0;
        while (sb.pending_answers.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= 5'(v);
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.nverts = v;
    endtask

    task automatic random_phase();
        int sel, nv, count;
        sel = $urandom_range(99);
        nv  = (sel < 7) ? NV_MAX : ((sel < 17) ? 1 : $urandom_range(2, 7));
        write_vertex_count(nv);
        if ($urandom_range(99) < 75)
        begin
            // well-formed: build a graph, relax it, read it back
            if ($urandom_range(1))
                send_request(REQ_CLEAR, 4'($urandom_range(15)), 4'($urandom_range(15)),
                             pick_weight());
            count = $urandom_range(1, (nv < 6) ? 2*nv : 12);
            repeat (count)
                send_request(REQ_EDGE, 4'($urandom_range(nv-1)), 4'($urandom_range(nv-1)),
                             pick_weight());
            send_request(REQ_RUN, 4'($urandom_range(15)), 4'($urandom_range(15)),
                         pick_weight());
            count = $urandom_range(2, 6);
            repeat (count)
                send_request(REQ_READ, 4'($urandom_range(nv-1)), 4'($urandom_range(nv-1)),
                             pick_weight());
            if ($urandom_range(3) == 0)
                send_request(req_t'($urandom_range(3)), 4'($urandom_range(15)),
                             4'($urandom_range(15)), dist_t'($urandom()));
        end
        else
        begin
            count = $urandom_range(4, 10);
            repeat (count)
                send_request(req_t'($urandom_range(3)), 4'($urandom_range(15)),
                             4'($urandom_range(15)), dist_t'($urandom()));
        end
    endtask

    initial
    begin
        int phase;
        sb           = new();
        sender_idles = 1'b1;
        rst_n        = 1'b0;
        start        = 1'b0;
        req_type     = REQ_CLEAR;
        vertex_a     = '0;
        vertex_b     = '0;
        weight       = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = 5'd16;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // directed part: reset contents, weight extremes, infinity edge,
        // saturation, a negative cycle, bad vertices and the vertex count limits
        write_vertex_count(16);
        send_request(REQ_READ, 4'd0, 4'd0, '0);
        send_request(REQ_READ, 4'd15, 4'd15, '0);
        send_request(REQ_EDGE, 4'd1, 4'd2, DIST_FIN_MAX);
        send_request(REQ_EDGE, 4'd2, 4'd3, DIST_FIN_MAX);
        send_request(REQ_EDGE, 4'd0, 4'd15, DIST_MIN);
        send_request(REQ_EDGE, 4'd4, 4'd5, DIST_INF);
        send_request(REQ_EDGE, 4'd6, 4'd7, dist_t'(-1));
        send_request(REQ_EDGE, 4'd7, 4'd8, dist_t'(5));
        send_request(REQ_EDGE, 4'd3, 4'd3, dist_t'(16));
        send_request(REQ_RUN, 4'd15, 4'd15, dist_t'($urandom()));
        send_request(REQ_READ, 4'd1, 4'd3, '0);
        send_request(REQ_READ, 4'd0, 4'd15, '0);
        send_request(REQ_READ, 4'd4, 4'd5, '0);
        send_request(REQ_READ, 4'd6, 4'd8, '0);
        send_request(REQ_READ, 4'd9, 4'd9, '0);
        send_request(REQ_CLEAR, 4'd15, 4'd0, DIST_MIN);
        send_request(REQ_READ, 4'd6, 4'd8, '0);
        write_vertex_count(3);
        send_request(REQ_EDGE, 4'd0, 4'd3, dist_t'(7));
        send_request(REQ_READ, 4'd15, 4'd1, '0);
        send_request(REQ_EDGE, 4'd0, 4'd2, dist_t'(32));
        send_request(REQ_RUN, 4'd0, 4'd0, '0);
        send_request(REQ_READ, 4'd2, 4'd0, '0);
        write_vertex_count(1);
        send_request(REQ_READ, 4'd0, 4'd0, '0);
        send_request(REQ_EDGE, 4'd0, 4'd1, dist_t'(3));
        send_request(REQ_EDGE, 4'd0, 4'd0, DIST_INF);
        send_request(REQ_RUN, 4'd0, 4'd0, '0);
        send_request(REQ_READ, 4'd0, 4'd0, '0);

        // random part, with a stretch of phases where the sender never pauses
        phase = 0;
        while (sb.n_useful + sb.n_bad < 130)
        begin
            sender_idles = !(phase >= 3 && phase < 6);
            random_phase();
            phase++;
        end
        start <= 1'b0;

        while (sb.pending_answers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        sb.check_leftovers();

        $display("covered %0d requests over %0d random phases: %0d runs, %0d edge writes,",
                 sb.n_checked, phase, sb.n_runs, sb.n_edges);
        $display("%0d reads, %0d clears, %0d out-of-range vertex requests, %0d errors",
                 sb.n_reads, sb.n_clears, sb.n_bad, sb.errors);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
